@@ rtl/mptm_pkg.sv @@
// mptm_pkg: shared types and constants of the motor protection trip monitor
// used by mptm_step and motor_protection_trip_monitor_unit; no dependencies
package mptm_pkg;

	localparam int TempW   = 10;
	localparam int CurW    = 16;
	localparam int SpdW    = 16;
	localparam int TimeW   = 16;
	localparam int StallW  = 17;
	localparam int CountW  = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;
	localparam int InDataW = 64;
	localparam int InUserW = 2;
	localparam int OutDataW = 24;

	localparam logic [StallW-1:0] StallMax = '1;

	// result mode codes, also the value driven on the output
	typedef enum logic [1:0] {
		MODE_RUN    = 2'd0,
		MODE_DERATE = 2'd1,
		MODE_TRIP   = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TRIP_TEMP    = 3'd0,
		CFG_TRIP_CUR     = 3'd1,
		CFG_STALL_LIMIT  = 3'd2,
		CFG_DERATE_TEMP  = 3'd3,
		CFG_RECOVER_TEMP = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_RESET = 1'b1
	} opcode_t;

	typedef struct packed {
		logic signed [TempW-1:0] trip_temperature;
		logic [CurW-1:0]         trip_current;
		logic [TimeW-1:0]        stall_limit_time;
		logic signed [TempW-1:0] derate_temperature;
		logic signed [TempW-1:0] recover_temperature;
	} cfg_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic                    reading_valid;
		logic signed [TempW-1:0] temperature;
		logic [CurW-1:0]         current;
		logic [SpdW-1:0]         speed;
		logic [TimeW-1:0]        elapsed_time;
	} item_t;

	typedef struct packed {
		mode_t             mode;
		logic [StallW-1:0] stall_acc;
		logic [CountW-1:0] trip_cnt;
	} guard_state_t;

	typedef struct packed {
		mode_t             mode;
		logic              reset_accepted;
		logic [CountW-1:0] trips_seen;
	} result_t;

endpackage

@@ rtl/mptm_step.sv @@
// mptm_step: next-state and result logic for one item of the trip monitor
// depends on mptm_pkg
module mptm_step (
	input  mptm_pkg::cfg_t         cfg,
	input  mptm_pkg::item_t        item,
	input  mptm_pkg::guard_state_t cur_state,
	output mptm_pkg::guard_state_t nxt_state,
	output mptm_pkg::result_t      result
);

	logic                            over_limit;
	logic                            stalled;
	logic [mptm_pkg::StallW:0]       stall_sum;
	logic [mptm_pkg::StallW-1:0]     stall_sat;
	logic                            stall_trip;
	logic                            accepted;
	logic                            trip_entry;

	assign over_limit = !item.reading_valid
		|| ($signed(item.temperature) >= $signed(cfg.trip_temperature))
		|| (item.current >= cfg.trip_current);
	assign stalled    = (item.speed == '0) && (item.current != '0);
	assign stall_sum  = {1'b0, cur_state.stall_acc}
		+ {{(mptm_pkg::StallW + 1 - mptm_pkg::TimeW){1'b0}}, item.elapsed_time};
	assign stall_sat  = stall_sum[mptm_pkg::StallW] ? mptm_pkg::StallMax
		: stall_sum[mptm_pkg::StallW-1:0];
	assign stall_trip = stall_sat >= {{(mptm_pkg::StallW - mptm_pkg::TimeW){1'b0}},
		cfg.stall_limit_time};

	always_comb begin
		nxt_state  = cur_state;
		accepted   = 1'b0;
		trip_entry = 1'b0;
		unique case (item.opcode)
			mptm_pkg::OP_RESET: begin
				if (cur_state.mode != mptm_pkg::MODE_TRIP) begin
					accepted = 1'b1;
				end else if (item.reading_valid
					&& ($signed(item.temperature) <= $signed(cfg.recover_temperature))) begin
					nxt_state.mode      = mptm_pkg::MODE_RUN;
					nxt_state.stall_acc = '0;
					accepted            = 1'b1;
				end
			end
			default: begin
				// a step while tripped changes nothing
				if (cur_state.mode != mptm_pkg::MODE_TRIP) begin
					priority if (over_limit) begin
						trip_entry = 1'b1;
					end else if (stalled && stall_trip) begin
						trip_entry = 1'b1;
					end else begin
						nxt_state.stall_acc = stalled ? stall_sat : '0;
						if ($signed(item.temperature) >= $signed(cfg.derate_temperature)) begin
							nxt_state.mode = mptm_pkg::MODE_DERATE;
						end else if (cur_state.mode == mptm_pkg::MODE_DERATE
							&& ($signed(item.temperature)
							<= $signed(cfg.recover_temperature))) begin
							nxt_state.mode = mptm_pkg::MODE_RUN;
						end
					end
				end
			end
		endcase
		if (trip_entry) begin
			nxt_state.mode      = mptm_pkg::MODE_TRIP;
			nxt_state.stall_acc = '0;
			nxt_state.trip_cnt  = cur_state.trip_cnt + 1'b1;
		end
		result.mode           = nxt_state.mode;
		result.reset_accepted = accepted;
		result.trips_seen     = nxt_state.trip_cnt;
	end

endmodule

@@ rtl/motor_protection_trip_monitor_unit.sv @@
// motor protection trip monitor: each input request passes the input register,
// then the result register; one request per cycle while the output is accepted,
// the step is a few compares and one 18-bit add between the two registers.
// reset (arst_n low, asynchronous) restores the register defaults, run mode,
// clears the stall time and trip count and empties both stages.
// depends on mptm_pkg and mptm_step
module motor_protection_trip_monitor_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mptm_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [mptm_pkg::CfgW-1:0]        cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// temperature[9:0], current[25:10], speed[41:26], elapsed_time[57:42], zeros
	input  logic [mptm_pkg::InDataW-1:0]     s_tdata,
	// opcode[0], reading_valid[1]
	input  logic [mptm_pkg::InUserW-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// mode[1:0], reset_accepted[2], trips_seen[18:3], zeros
	output logic [mptm_pkg::OutDataW-1:0]    m_tdata
);

	mptm_pkg::cfg_t         cfg_q;
	mptm_pkg::item_t        item_s1;
	logic                   valid_s1;
	mptm_pkg::guard_state_t state_q;
	mptm_pkg::guard_state_t nxt_state;
	mptm_pkg::result_t      result;
	mptm_pkg::result_t      result_q;
	logic                   out_valid_q;
	logic                   advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_temperature    <= 10'sd120;
			cfg_q.trip_current        <= 16'd20000;
			cfg_q.stall_limit_time    <= 16'd2000;
			cfg_q.derate_temperature  <= 10'sd90;
			cfg_q.recover_temperature <= 10'sd80;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mptm_pkg::CFG_TRIP_TEMP:
					cfg_q.trip_temperature <= cfg_data[mptm_pkg::TempW-1:0];
				mptm_pkg::CFG_TRIP_CUR:
					cfg_q.trip_current <= cfg_data[mptm_pkg::CurW-1:0];
				mptm_pkg::CFG_STALL_LIMIT:
					cfg_q.stall_limit_time <= cfg_data[mptm_pkg::TimeW-1:0];
				mptm_pkg::CFG_DERATE_TEMP:
					cfg_q.derate_temperature <= cfg_data[mptm_pkg::TempW-1:0];
				mptm_pkg::CFG_RECOVER_TEMP:
					cfg_q.recover_temperature <= cfg_data[mptm_pkg::TempW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode        <= mptm_pkg::opcode_t'(s_tuser[0]);
			item_s1.reading_valid <= s_tuser[1];
			item_s1.temperature   <= s_tdata[9:0];
			item_s1.current       <= s_tdata[25:10];
			item_s1.speed         <= s_tdata[41:26];
			item_s1.elapsed_time  <= s_tdata[57:42];
		end
	end

	mptm_step u_step (
		.cfg       (cfg_q),
		.item      (item_s1),
		.cur_state (state_q),
		.nxt_state (nxt_state),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= mptm_pkg::MODE_RUN;
			state_q.stall_acc <= '0;
			state_q.trip_cnt  <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= nxt_state;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mptm_pkg::OutDataW - 19){1'b0}}, result_q.trips_seen,
		result_q.reset_accepted, result_q.mode};

	// the trip count only moves when the block enters trip
	a_cnt_on_trip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.trip_cnt != $past(state_q.trip_cnt)) |-> (state_q.mode == mptm_pkg::MODE_TRIP))
		else $error("trip count changed without entering trip");

	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == mptm_pkg::MODE_TRIP) |-> (state_q.stall_acc == '0))
		else $error("stall time held while tripped");

	// an accepted reset never leaves the block tripped
	a_reset_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.reset_accepted) |-> (result_q.mode != mptm_pkg::MODE_TRIP))
		else $error("accepted reset reports trip mode");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(state_q))
		else $error("state changed without a request");

endmodule

@@ bench/tb_motor_protection_trip_monitor_unit.sv @@
// self-checking bench for motor_protection_trip_monitor_unit: queued sensor requests
// are driven on the input stream and every result is checked against a local predictor.
// depends on mptm_pkg and the unit's rtl only
module tb_motor_protection_trip_monitor_unit;
	import mptm_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int CfgSlots   = 1 << CfgIdxW;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	// temperature[9:0], current[25:10], speed[41:26], elapsed_time[57:42], zeros
	logic [InDataW-1:0]  s_tdata   = '0;
	// opcode[0], reading_valid[1]
	logic [InUserW-1:0]  s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	// mode[1:0], reset_accepted[2], trips_seen[18:3], zeros
	logic [OutDataW-1:0] m_tdata;

	motor_protection_trip_monitor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// limits as the unit holds them
	logic signed [TempW-1:0] lim_trip_temp    = 10'sd120;
	logic [CurW-1:0]         lim_trip_cur     = 16'd20000;
	logic [TimeW-1:0]        lim_stall        = 16'd2000;
	logic signed [TempW-1:0] lim_derate_temp  = 10'sd90;
	logic signed [TempW-1:0] lim_recover_temp = 10'sd80;

	// protection state as the unit should hold it
	mode_t             prot_mode = MODE_RUN;
	logic [StallW-1:0] exp_stall = '0;
	logic [CountW-1:0] exp_trips = '0;

	item_t   sample_q[$];
	result_t verdict_q[$];
	item_t   on_bus;
	result_t got, want;
	int      send_idle    = 0;
	int      recv_idle    = 0;
	int      mismatches   = 0;
	int      results_seen = 0;
	int      cycles       = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void latch_trip();
		if (prot_mode != MODE_TRIP)
			exp_trips = exp_trips + 1'b1;
		prot_mode = MODE_TRIP;
		exp_stall = '0;
	endfunction

	function automatic result_t protect_step(input item_t it);
		result_t r;
		logic signed [TempW-1:0] t;
		logic [StallW:0] acc_sum;
		logic stall_trip;
		t = it.temperature;
		stall_trip = 1'b0;
		r.reset_accepted = 1'b0;
		if (it.opcode == OP_RESET) begin
			if (prot_mode != MODE_TRIP) begin
				r.reset_accepted = 1'b1;
			end else if (it.reading_valid && t <= lim_recover_temp) begin
				prot_mode = MODE_RUN;
				exp_stall = '0;
				r.reset_accepted = 1'b1;
			end
		end else if (prot_mode != MODE_TRIP) begin
			if (!it.reading_valid || t >= lim_trip_temp || it.current >= lim_trip_cur) begin
				latch_trip();
			end else begin
				if (it.speed == '0 && it.current != '0) begin
					acc_sum = {1'b0, exp_stall} + it.elapsed_time;
					exp_stall = acc_sum[StallW] ? StallMax : acc_sum[StallW-1:0];
					if (exp_stall >= lim_stall) begin
						latch_trip();
						stall_trip = 1'b1;
					end
				end else begin
					exp_stall = '0;
				end
				if (!stall_trip) begin
					if (t >= lim_derate_temp)
						prot_mode = MODE_DERATE;
					else if (prot_mode == MODE_DERATE && t <= lim_recover_temp)
						prot_mode = MODE_RUN;
				end
			end
		end
		r.mode = prot_mode;
		r.trips_seen = exp_trips;
		return r;
	endfunction

	function automatic item_t mk_sample(input opcode_t op, input logic ok, input int t,
			input int c, input int s, input int dt);
		item_t it;
		it.opcode = op;
		it.reading_valid = ok;
		it.temperature = t[TempW-1:0];
		it.current = c[CurW-1:0];
		it.speed = s[SpdW-1:0];
		it.elapsed_time = dt[TimeW-1:0];
		return it;
	endfunction

	// readings cluster around the current limits so that modes actually change
	function automatic item_t random_sample();
		item_t it;
		int t;
		int c;
		int pick;
		it.opcode = ($urandom_range(99) < 15) ? OP_RESET : OP_STEP;
		it.reading_valid = ($urandom_range(99) < 94);
		pick = $urandom_range(9);
		case (pick)
			0: t = int'($urandom_range(1023)) - 512;
			1, 2, 3: t = int'(lim_derate_temp) + int'($urandom_range(6)) - 3;
			4, 5: t = int'(lim_recover_temp) + int'($urandom_range(6)) - 3;
			6: t = int'(lim_trip_temp) + int'($urandom_range(6)) - 3;
			default: t = int'(lim_recover_temp) - 30 + int'($urandom_range(40));
		endcase
		if (t < -512) t = -512;
		if (t > 511) t = 511;
		it.temperature = t[TempW-1:0];
		pick = $urandom_range(9);
		case (pick)
			0: c = $urandom_range(65535);
			1: c = 0;
			2: c = int'(lim_trip_cur) + int'($urandom_range(4)) - 2;
			default: c = (lim_trip_cur == '0) ? 0 : $urandom_range(int'(lim_trip_cur) - 1);
		endcase
		if (c < 0) c = 0;
		if (c > 65535) c = 65535;
		it.current = c[CurW-1:0];
		pick = $urandom_range(9);
		if (pick < 5)
			it.speed = '0;
		else if (pick == 5)
			it.speed = 16'($urandom_range(65535));
		else
			it.speed = 16'($urandom_range(3000));
		pick = $urandom_range(9);
		if (pick == 0)
			it.elapsed_time = 16'($urandom_range(65535));
		else if (pick == 1)
			it.elapsed_time = '0;
		else if (pick < 4)
			it.elapsed_time = 16'($urandom_range(int'(lim_stall)));
		else
			it.elapsed_time = 16'($urandom_range(int'(lim_stall) / 4 + 1));
		return it;
	endfunction

	task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TRIP_TEMP:    lim_trip_temp = val[TempW-1:0];
			CFG_TRIP_CUR:     lim_trip_cur = val[CurW-1:0];
			CFG_STALL_LIMIT:  lim_stall = val[TimeW-1:0];
			CFG_DERATE_TEMP:  lim_derate_temp = val[TempW-1:0];
			CFG_RECOVER_TEMP: lim_recover_temp = val[TempW-1:0];
			default: ;
		endcase
	endtask

	// also hits an unused index, which must leave every limit alone
	task automatic apply_limits(input int trip_t, input int trip_c, input int stall_t,
			input int derate_t, input int recover_t);
		write_limit(CFG_TRIP_TEMP, 16'(trip_t));
		write_limit(CFG_TRIP_CUR, 16'(trip_c));
		write_limit(CFG_STALL_LIMIT, 16'(stall_t));
		write_limit(CFG_DERATE_TEMP, 16'(derate_t));
		write_limit(CFG_RECOVER_TEMP, 16'(recover_t));
		write_limit(CfgIdxW'($urandom_range(CfgSlots - 1, CFG_RECOVER_TEMP + 1)),
			16'($urandom_range(65535)));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// sender holds off until every outstanding request has its result
	task automatic settle();
		while (sample_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				verdict_q.push_back(protect_step(on_bus));
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					on_bus = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= InDataW'({on_bus.elapsed_time, on_bus.speed,
						on_bus.current, on_bus.temperature});
					s_tuser <= {on_bus.reading_valid, on_bus.opcode};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.mode = mode_t'(m_tdata[1:0]);
				got.reset_accepted = m_tdata[2];
				got.trips_seen = m_tdata[18:3];
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d with no request outstanding: mode %0d acc %0b trips %0d",
							results_seen, got.mode, got.reset_accepted, got.trips_seen);
				end else begin
					want = verdict_q.pop_front();
					if (got.mode !== want.mode || got.reset_accepted !== want.reset_accepted ||
							got.trips_seen !== want.trips_seen) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected mode %0d acc %0b trips %0d, got mode %0d acc %0b trips %0d",
								results_seen, want.mode, want.reset_accepted, want.trips_seen,
								got.mode, got.reset_accepted, got.trips_seen);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("motor_protection_trip_monitor_unit verification failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 27;
		recv_idle = 64;
		// derate entry, hold and recovery, each at its threshold
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 25, 1000, 1500, 10));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 90, 1000, 1500, 10));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 85, 1000, 1500, 10));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 80, 1000, 1500, 10));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, 100, 0, 0, 0));
		// stall time builds up to the limit exactly
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 500, 0, 1500));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 500, 0, 500));
		sample_q.push_back(mk_sample(OP_STEP, 1'b0, 511, 65535, 0, 65535));
		sample_q.push_back(mk_sample(OP_RESET, 1'b0, 0, 0, 0, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, 81, 0, 0, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, 80, 0, 0, 0));
		sample_q.push_back(mk_sample(OP_STEP, 1'b0, 0, 0, 0, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, -512, 65535, 65535, 65535));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 120, 0, 100, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, 0, 0, 0, 0));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 0, 20000, 100, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, 0, 0, 0, 0));
		// a turning rotor clears the stall time
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 500, 0, 1999));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 500, 1, 0));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 500, 0, 1999));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 30, 0, 0, 65535));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 119, 19999, 65535, 65535));
		settle();
		repeat (130) sample_q.push_back(random_sample());
		settle();
		apply_limits(100, 15000, 400, 60, 50);
		repeat (150) sample_q.push_back(random_sample());
		settle();

		send_idle = 64;
		recv_idle = 27;
		apply_limits(511, 65535, 65535, -512, 511);
		// largest stall sum the accumulator can see
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 0, 100, 0, 65534));
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, 0, 100, 0, 65535));
		repeat (150) sample_q.push_back(random_sample());
		settle();
		apply_limits(-512, 0, 0, 511, -512);
		repeat (110) sample_q.push_back(random_sample());
		settle();

		send_idle = 0;
		recv_idle = 0;
		apply_limits(0, 300, 0, -20, -30);
		// zero stall limit trips even with no elapsed time
		sample_q.push_back(mk_sample(OP_STEP, 1'b1, -100, 100, 0, 0));
		sample_q.push_back(mk_sample(OP_RESET, 1'b1, -100, 0, 0, 0));
		repeat (150) sample_q.push_back(random_sample());
		settle();
		apply_limits(int'($urandom_range(1023)) - 512, $urandom_range(65535),
			$urandom_range(4000), int'($urandom_range(1023)) - 512,
			int'($urandom_range(1023)) - 512);
		repeat (150) sample_q.push_back(random_sample());
		settle();

		if (mismatches == 0)
			$display("motor_protection_trip_monitor_unit verification clean");
		else
			$display("motor_protection_trip_monitor_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mptm_pkg.sv
rtl/mptm_step.sv
rtl/motor_protection_trip_monitor_unit.sv
bench/tb_motor_protection_trip_monitor_unit.sv
